// ===== rtl/drm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drm_pkg - shared types and constants of the drum mix ring buffer
// Operation and command codes, queue entry layout, volume scaling helpers.
// ----------------------------------------------------------------------------
package drm_pkg;

  // ring and playback constants
  localparam int RING_DEPTH_DEF = 512;
  localparam int CHUNK_LENGTH   = 64;
  localparam int READ_START     = 0;
  localparam int WRITE_START    = 256;
  localparam int VOLUME_STEPS   = 8;
  localparam int DEFAULT_VOLUME = 6;

  localparam int GROUPS      = 4;
  localparam int VOICES      = 6;
  localparam int SAMPLE_W    = 16;
  localparam int VOICE_W     = 8;
  localparam int VOL_W       = 4;
  localparam int PROD_W      = 12;
  localparam int IN_DATA_W   = 56;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [SAMPLE_W-1:0] MID_LEVEL = 16'd511;
  localparam logic [VOL_W-1:0]    VOL_MAX   = VOL_W'(VOLUME_STEPS);
  localparam logic [VOL_W-1:0]    VOL_INIT  = VOL_W'(DEFAULT_VOLUME);

  // reciprocal for the truncating divide by the volume steps
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((2 ** RECIP_SHIFT + VOLUME_STEPS - 1) / VOLUME_STEPS);

  // input operation codes
  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_VOLUME = 2'd1,
    OP_FRAME  = 2'd2,
    OP_TICK   = 2'd3
  } op_t;

  // commands handed from the front to the back
  typedef enum logic [1:0] {
    CMD_FILL = 2'd0,
    CMD_MIX  = 2'd1,
    CMD_TICK = 2'd2
  } cmd_t;

  typedef logic signed [PROD_W-1:0] prod_t;

  typedef struct packed {
    cmd_t                cmd;
    logic                chunk;
    prod_t [VOICES-1:0]  prod;
  } q_entry_t;

  // signed sample times unsigned volume, low bits of a two's complement product
  function automatic prod_t mul_volume(input logic [VOICE_W-1:0] s,
                                       input logic [VOL_W-1:0] v);
    logic [PROD_W:0] a;
    logic [PROD_W:0] b;
    logic [PROD_W:0] p;
    a = {{(PROD_W + 1 - VOICE_W){s[VOICE_W-1]}}, s};
    b = {{(PROD_W + 1 - VOL_W){1'b0}}, v};
    p = a * b;
    return p[PROD_W-1:0];
  endfunction

  // divide by the volume steps, truncating toward zero
  function automatic prod_t div_steps(input prod_t p);
    logic [PROD_W-1:0]         mag;
    logic [PROD_W+RECIP_W-1:0] full;
    logic [PROD_W-1:0]         qm;
    mag  = p[PROD_W-1] ? (~p + 1'b1) : p;
    full = (PROD_W + RECIP_W)'(mag) * (PROD_W + RECIP_W)'(RECIP);
    qm   = full[RECIP_SHIFT +: PROD_W];
    return p[PROD_W-1] ? (~qm + 1'b1) : qm;
  endfunction

endpackage

// ===== rtl/drm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drm_ram - generic simple dual port ram
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module drm_ram import drm_pkg::*; #(
  parameter int WIDTH = SAMPLE_W,
  parameter int DEPTH = RING_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/drm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drm_front - input side of the drum mix block
// Accepts beats, keeps group volumes and the playing flag, scales voices
// and pushes mix, tick and fill commands into the queue.
// ----------------------------------------------------------------------------
module drm_front import drm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic [1:0]           in_tuser,
  input  logic                 fill_busy,
  output logic                 push_valid,
  input  logic                 push_ready,
  output q_entry_t             push_data
);

  logic [VOL_W-1:0] vol_r   [GROUPS];
  logic [VOL_W-1:0] vol_nxt [GROUPS];
  logic             playing_r;
  logic             playing_nxt;

  logic             accept;
  op_t              op;
  logic             chunk;
  logic [2:0]       group_index;
  logic             louder;
  logic [VOICE_W-1:0] sample [VOICES];
  logic [VOL_W-1:0]   lane_vol [VOICES];

  // field unpacking
  assign op          = op_t'(in_tuser);
  assign chunk       = in_tdata[0];
  assign group_index = in_tdata[51:49];
  assign louder      = in_tdata[52];

  always_comb begin
    for (int i = 0; i < VOICES; i++) begin
      sample[i] = in_tdata[1 + i * VOICE_W +: VOICE_W];
    end
  end

  // toms share group 2, hats share group 3
  assign lane_vol[0] = vol_r[0];
  assign lane_vol[1] = vol_r[1];
  assign lane_vol[2] = vol_r[2];
  assign lane_vol[3] = vol_r[2];
  assign lane_vol[4] = vol_r[3];
  assign lane_vol[5] = vol_r[3];

  // beats wait while the ring is swept or the queue is full
  assign in_tready = !fill_busy && push_ready;
  assign accept    = in_tvalid && in_tready;

  // classify the beat
  always_comb begin
    push_valid      = 1'b0;
    push_data.cmd   = CMD_TICK;
    push_data.chunk = chunk;
    for (int i = 0; i < VOICES; i++) begin
      push_data.prod[i] = mul_volume(sample[i], lane_vol[i]);
    end
    unique case (op)
      OP_START: begin
        push_valid    = accept;
        push_data.cmd = CMD_FILL;
      end
      OP_VOLUME: begin
        push_valid = 1'b0;
      end
      OP_FRAME: begin
        push_valid    = accept && playing_r;
        push_data.cmd = CMD_MIX;
      end
      OP_TICK: begin
        push_valid    = accept;
        push_data.cmd = CMD_TICK;
      end
      default: begin
        push_valid = 1'b0;
      end
    endcase
  end

  // volume steps and playback flag
  always_comb begin
    playing_nxt = playing_r;
    for (int g = 0; g < GROUPS; g++) begin
      vol_nxt[g] = vol_r[g];
    end
    if (accept && op == OP_START) begin
      playing_nxt = 1'b1;
    end
    if (accept && op == OP_VOLUME && !group_index[2]) begin
      if (louder) begin
        if (vol_r[group_index[1:0]] < VOL_MAX) begin
          vol_nxt[group_index[1:0]] = vol_r[group_index[1:0]] + 1'b1;
        end
      end else begin
        if (vol_r[group_index[1:0]] != '0) begin
          vol_nxt[group_index[1:0]] = vol_r[group_index[1:0]] - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      playing_r <= 1'b0;
      for (int g = 0; g < GROUPS; g++) begin
        vol_r[g] <= VOL_INIT;
      end
    end else begin
      playing_r <= playing_nxt;
      for (int g = 0; g < GROUPS; g++) begin
        vol_r[g] <= vol_nxt[g];
      end
    end
  end

endmodule

// ===== rtl/drm_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drm_queue - short command queue between front and back
// Small flop based fifo, full and empty from an occupancy count.
// ----------------------------------------------------------------------------
module drm_queue import drm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  q_entry_t push_data,
  output logic     pop_valid,
  input  logic     pop_ready,
  output q_entry_t pop_data
);

  localparam int QAW = $clog2(QUEUE_DEPTH);
  localparam logic [QAW-1:0] LAST_SLOT = QAW'(QUEUE_DEPTH - 1);
  localparam logic [QAW:0]   FULL_CNT  = (QAW + 1)'(QUEUE_DEPTH);

  q_entry_t       slot_r [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   count_r, count_nxt;
  logic           do_push, do_pop;

  assign push_ready = (count_r != FULL_CNT);
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/drm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drm_back - execution side of the drum mix block
// Divides and sums voice terms, keeps the ring pointers, sweeps the ring
// with the mid level and reads samples out for the pwm stream.
// ----------------------------------------------------------------------------
module drm_back import drm_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  q_entry_t            pop_data,
  output logic                fill_busy,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [SAMPLE_W-1:0] out_tdata
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam logic [AW-1:0] LAST_POS   = AW'(RING_DEPTH - 1);
  localparam logic [AW-1:0] READ_POS0  = AW'(READ_START % RING_DEPTH);
  localparam logic [AW-1:0] WRITE_POS0 = AW'(WRITE_START % RING_DEPTH);
  localparam bit            CHUNK_ALL  = (CHUNK_LENGTH >= RING_DEPTH);
  localparam logic [AW-1:0] CHUNK_POS  = AW'(CHUNK_LENGTH % RING_DEPTH);
  localparam logic [AW:0]   DEPTH_EXT  = (AW + 1)'(RING_DEPTH);

  function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] p);
    return (p == LAST_POS) ? '0 : p + 1'b1;
  endfunction

  // stage 1: quotients
  logic               s1_valid_r;
  cmd_t               s1_cmd_r;
  logic               s1_chunk_r;
  prod_t [VOICES-1:0] s1_q_r;

  // stage 2: mixed sample, pointer work
  logic                s2_valid_r;
  cmd_t                s2_cmd_r;
  logic                s2_chunk_r;
  logic [SAMPLE_W-1:0] s2_mix_r;

  logic [AW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic                phase_r, phase_nxt;
  logic                fill_busy_r, fill_busy_nxt;
  logic [AW-1:0]       fill_cnt_r, fill_cnt_nxt;
  logic                rd_pend_r, rd_pend_nxt;
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_data_r;

  logic                s2_block, s2_go, s2_free, s1_free;
  logic [SAMPLE_W-1:0] mix_sum;
  logic [AW:0]         diff;
  logic [AW-1:0]       lead_gap;
  logic                realign;
  logic [AW-1:0]       wr_base;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [SAMPLE_W-1:0] ram_wdata, ram_rdata;

  // pipeline flow; an emitting tick waits for a free output register
  assign s2_block  = fill_busy_r ||
                     (s2_cmd_r == CMD_TICK && phase_r && (rd_pend_r || out_valid_r));
  assign s2_go     = s2_valid_r && !s2_block;
  assign s2_free   = !s2_valid_r || s2_go;
  assign s1_free   = !s1_valid_r || s2_free;
  assign pop_ready = s1_free;
  assign fill_busy = fill_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_r <= pop_valid;
      end
      if (s2_free) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  // stage 1 payload: per voice truncating divide
  always_ff @(posedge clk) begin
    if (s1_free && pop_valid) begin
      s1_cmd_r   <= pop_data.cmd;
      s1_chunk_r <= pop_data.chunk;
      for (int i = 0; i < VOICES; i++) begin
        s1_q_r[i] <= div_steps(pop_data.prod[i]);
      end
    end
  end

  // base level plus six terms, wrapping at 16 bits
  always_comb begin
    mix_sum = MID_LEVEL;
    for (int i = 0; i < VOICES; i++) begin
      mix_sum = mix_sum + {{(SAMPLE_W - PROD_W){s1_q_r[i][PROD_W-1]}}, s1_q_r[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && s1_valid_r) begin
      s2_cmd_r   <= s1_cmd_r;
      s2_chunk_r <= s1_chunk_r;
      s2_mix_r   <= mix_sum;
    end
  end

  // distance from write to read position around the ring
  always_comb begin
    diff = {1'b0, rd_ptr_r} - {1'b0, wr_ptr_r};
    if (diff[AW]) begin
      diff = diff + DEPTH_EXT;
    end
    lead_gap = diff[AW-1:0];
  end

  assign realign = s2_chunk_r && (CHUNK_ALL || lead_gap < CHUNK_POS);
  assign wr_base = realign ? WRITE_POS0 : wr_ptr_r;

  // stage 2 execute and ring sweep
  always_comb begin
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    phase_nxt     = phase_r;
    fill_busy_nxt = fill_busy_r;
    fill_cnt_nxt  = fill_cnt_r;
    rd_pend_nxt   = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = wr_base;
    ram_wdata     = s2_mix_r;
    ram_re        = 1'b0;
    ram_raddr     = rd_ptr_r;
    if (fill_busy_r) begin
      ram_we       = 1'b1;
      ram_waddr    = fill_cnt_r;
      ram_wdata    = MID_LEVEL;
      fill_cnt_nxt = next_pos(fill_cnt_r);
      if (fill_cnt_r == LAST_POS) begin
        fill_busy_nxt = 1'b0;
      end
    end else if (s2_go) begin
      unique case (s2_cmd_r)
        CMD_FILL: begin
          fill_busy_nxt = 1'b1;
          fill_cnt_nxt  = '0;
          rd_ptr_nxt    = READ_POS0;
          wr_ptr_nxt    = WRITE_POS0;
        end
        CMD_MIX: begin
          ram_we     = 1'b1;
          wr_ptr_nxt = next_pos(wr_base);
          if (realign) begin
            rd_ptr_nxt = READ_POS0;
          end
        end
        CMD_TICK: begin
          if (!phase_r) begin
            phase_nxt = 1'b1;
          end else begin
            phase_nxt   = 1'b0;
            ram_re      = 1'b1;
            rd_pend_nxt = 1'b1;
            rd_ptr_nxt  = next_pos(rd_ptr_r);
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  // reset starts a sweep of the whole ring
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      phase_r     <= 1'b0;
      fill_busy_r <= 1'b1;
      fill_cnt_r  <= '0;
      rd_pend_r   <= 1'b0;
    end else begin
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      phase_r     <= phase_nxt;
      fill_busy_r <= fill_busy_nxt;
      fill_cnt_r  <= fill_cnt_nxt;
      rd_pend_r   <= rd_pend_nxt;
    end
  end

  drm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rd_pend_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend_r) begin
      out_data_r <= ram_rdata;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/drum_mix_ring_buffer_pwm_feed.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drum_mix_ring_buffer_pwm_feed - drum voice mixer with ring buffer pwm feed
// Input beats carry start, volume, frame and tick operations; the output
// stream carries one pwm compare value for every second tick.
// ----------------------------------------------------------------------------
// Usage:
//   in_* carries one operation per beat, in_tuser selects it (start, volume
//   step, mix frame, output tick). out_* carries pwm samples read from the
//   ring buffer at the read position.
//   Throughput: one beat per cycle for frames, volume steps and silent ticks
//   while no sweep runs and the queue has room; an emitting tick holds the
//   execute stage until the ram read and the output register are free.
//   Path: an emitting tick reaches out_tvalid through the queue, the divide
//   stage, the execute stage with ram read and the output register.
//   Reset: the ring is swept with the mid level 511, one entry per cycle,
//   with in_tready low. A start beat causes the same sweep once it reaches
//   the execute stage.
//   Stall: the output register holds a sample until out_tready; the next
//   emitting tick waits in the execute stage, one beat waits in the divide
//   stage and in_tready drops once four more beats fill the queue.
// ----------------------------------------------------------------------------
module drum_mix_ring_buffer_pwm_feed import drm_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // chunk_start, kick, clap, low_tom, high_tom, closed_hat, open_hat samples,
  // group_index, louder, zero pad
  input  logic [IN_DATA_W-1:0] in_tdata,
  // operation
  input  logic [1:0]           in_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // pwm_value
  output logic [SAMPLE_W-1:0]  out_tdata
);

  logic     fill_busy;
  logic     push_valid, push_ready;
  q_entry_t push_data;
  logic     pop_valid, pop_ready;
  q_entry_t pop_data;

  drm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .fill_busy  (fill_busy),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  drm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  drm_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .fill_busy  (fill_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== rtl/drm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drm_checker - port level checks of the drum mix block
// Reset behavior and beat holding on both streams, bound to the top level.
// ----------------------------------------------------------------------------
module drm_checker import drm_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_tvalid,
  input logic                 in_tready,
  input logic [IN_DATA_W-1:0] in_tdata,
  input logic [1:0]           in_tuser,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [SAMPLE_W-1:0]  out_tdata
);

  // a stalled output beat keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output beat changed while stalled");

  // a waiting input beat keeps its value
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata) && $stable(in_tuser))
    else $error("input beat changed while waiting");

  // reset empties the output register
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // the ring sweep after reset keeps the input closed
  a_reset_sweep: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input ready during reset sweep");

endmodule

bind drum_mix_ring_buffer_pwm_feed drm_checker u_drm_checker (.*);
